FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VEA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define VEA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// Plain check at every clock edge, reset included.
`define VEA_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) (expr)) \
		else $error("invariant check failed");

`endif

FILE: sv/vea_pkg.sv
// Package with the shared types and constants of the vibration energy accumulator.
package vea_pkg;

	localparam int NUM_AXES  = 3;
	localparam int SUM_W     = 32;
	localparam int NUM_OUT   = 11;
	localparam int CFG_IDX_W = 3;
	localparam int SHIFT_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CALIB_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_X           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_Y           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_Z           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_SHIFT = 3'd4;

	typedef struct packed {
		logic clear;
		logic done;
		logic wake;
	} item_ctrl_t;

	typedef struct packed {
		logic take;
		logic wake;
		logic done;
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctrl_t;

endpackage

FILE: sv/vibration_energy_accumulator.sv
// Top level of the vibration energy accumulator.
// One input beat is taken every clock cycle while no result waiting at the output
// stalls the lanes, and each beat gives one result beat. The oversample register,
// the average and deviation stage and the squaring stage of the three axis lanes
// follow in that order, and the merge stage adds into the window sums as the result
// enters the output register. Up to three beats sit in the lanes while a result
// waits to be taken. Configuration writes must only be made while the block holds
// no beat whose result has not been delivered.
module vibration_energy_accumulator #(
	parameter int ADC_BITS  = 12,
	parameter int MAX_SHIFT = 6,
	localparam int IN_W  = ((5 * ADC_BITS + 7) / 8) * 8,
	localparam int OUT_W = vea_pkg::NUM_OUT * vea_pkg::SUM_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ADC_BITS-1:0]             cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// raw_x, raw_y, raw_z, ntc_one, ntc_two, zero fill
	input  logic [IN_W-1:0]                 s_axis_tdata,
	// op, wake_start
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// square_sum_x/y/z, linear_sum_x/y/z, ntc_sum_one, ntc_sum_two,
	// ntc_samples, window_samples, all_samples
	output logic [OUT_W-1:0]                m_axis_tdata
);

	localparam int N     = vea_pkg::NUM_AXES;
	localparam int AVG_W = ADC_BITS + MAX_SHIFT;
	localparam int DEV_W = AVG_W + 1;
	localparam int SQ_W  = 2 * DEV_W;
	localparam int SH_W  = (MAX_SHIFT > 7) ? 4 : 3;
	localparam int CNT_W = MAX_SHIFT + 1;

	logic                          calib_mode_q;
	logic [ADC_BITS-1:0]           zero_q [N];
	logic [vea_pkg::SHIFT_W-1:0]   shift_q;
	logic [SH_W-1:0]               shift_eff;

	logic [CNT_W-1:0]              over_count_q;
	logic [CNT_W-1:0]              count_next;
	logic [CNT_W-1:0]              target;
	logic                          op;
	logic                          wake;
	logic                          done;
	logic                          accept;
	logic                          take;
	logic [ADC_BITS-1:0]           raw [N];
	logic [ADC_BITS-1:0]           ntc_one_in;
	logic [ADC_BITS-1:0]           ntc_two_in;

	logic                          v_s1;
	logic                          v_s2;
	logic                          v_s3;
	logic                          en1;
	logic                          en2;
	logic                          en3;
	logic                          move;
	vea_pkg::item_ctrl_t           ctrl_s1;
	vea_pkg::item_ctrl_t           ctrl_s2;
	vea_pkg::item_ctrl_t           ctrl_s3;
	logic [ADC_BITS-1:0]           ntc_one_s1;
	logic [ADC_BITS-1:0]           ntc_two_s1;
	logic [ADC_BITS-1:0]           ntc_one_s2;
	logic [ADC_BITS-1:0]           ntc_two_s2;
	logic [ADC_BITS-1:0]           ntc_one_s3;
	logic [ADC_BITS-1:0]           ntc_two_s3;
	vea_pkg::lane_ctrl_t           lane_ctrl;

	logic [AVG_W-1:0]              avg_l [N];
	logic [DEV_W-1:0]              dev_l [N];
	logic [SQ_W-1:0]               sq_l  [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_mode_q <= 1'b1;
			for (int a = 0; a < N; a++) begin
				zero_q[a] <= ADC_BITS'(1) << (ADC_BITS - 1);
			end
			shift_q <= vea_pkg::SHIFT_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				vea_pkg::REG_CALIB_MODE: begin
					calib_mode_q <= cfg_data[0];
				end
				vea_pkg::REG_ZERO_X: begin
					zero_q[0] <= cfg_data;
				end
				vea_pkg::REG_ZERO_Y: begin
					zero_q[1] <= cfg_data;
				end
				vea_pkg::REG_ZERO_Z: begin
					zero_q[2] <= cfg_data;
				end
				vea_pkg::REG_OVERSAMPLE_SHIFT: begin
					shift_q <= cfg_data[vea_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign shift_eff = (SH_W'(shift_q) > SH_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : SH_W'(shift_q);

	assign op         = s_axis_tuser[0];
	assign wake       = s_axis_tuser[1];
	assign ntc_one_in = s_axis_tdata[3*ADC_BITS +: ADC_BITS];
	assign ntc_two_in = s_axis_tdata[4*ADC_BITS +: ADC_BITS];

	always_comb begin
		for (int a = 0; a < N; a++) begin
			raw[a] = s_axis_tdata[a*ADC_BITS +: ADC_BITS];
		end
	end

	assign count_next = (wake ? '0 : over_count_q) + CNT_W'(1);
	assign target     = CNT_W'(1) << shift_eff;
	assign done       = count_next >= target;
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign take       = accept && !op;

	assign en3           = !v_s3 || move;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_count_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			if (take) begin
				over_count_q <= done ? '0 : count_next;
			end
			if (en1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ctrl_s1.clear <= op;
			ctrl_s1.done  <= done && !op;
			ctrl_s1.wake  <= wake && !op;
			ntc_one_s1    <= ntc_one_in;
			ntc_two_s1    <= ntc_two_in;
		end
		if (en2) begin
			ctrl_s2    <= ctrl_s1;
			ntc_one_s2 <= ntc_one_s1;
			ntc_two_s2 <= ntc_two_s1;
		end
		if (en3) begin
			ctrl_s3    <= ctrl_s2;
			ntc_one_s3 <= ntc_one_s2;
			ntc_two_s3 <= ntc_two_s2;
		end
	end

	assign lane_ctrl.take  = take;
	assign lane_ctrl.wake  = wake;
	assign lane_ctrl.done  = done;
	assign lane_ctrl.en_s1 = en1;
	assign lane_ctrl.en_s2 = en2;
	assign lane_ctrl.en_s3 = en3;

	for (genvar g = 0; g < N; g++) begin : g_lane
		vea_lane #(
			.ADC_BITS  (ADC_BITS),
			.MAX_SHIFT (MAX_SHIFT)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.raw    (raw[g]),
			.zero   (zero_q[g]),
			.shift  (shift_eff),
			.avg    (avg_l[g]),
			.dev    (dev_l[g]),
			.sq     (sq_l[g])
		);
	end

	vea_merge #(
		.ADC_BITS  (ADC_BITS),
		.MAX_SHIFT (MAX_SHIFT)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s3),
		.ctrl       (ctrl_s3),
		.calib_mode (calib_mode_q),
		.ntc_one    (ntc_one_s3),
		.ntc_two    (ntc_two_s3),
		.avg        (avg_l),
		.dev        (dev_l),
		.sq         (sq_l),
		.move       (move),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_data   (m_axis_tdata)
	);

endmodule

FILE: sv/vea_lane.sv
// One axis lane: oversample accumulation, averaging, deviation and squaring.
module vea_lane #(
	parameter int ADC_BITS  = 12,
	parameter int MAX_SHIFT = 6,
	localparam int AVG_W = ADC_BITS + MAX_SHIFT,
	localparam int DEV_W = AVG_W + 1,
	localparam int SQ_W  = 2 * DEV_W,
	localparam int SH_W  = (MAX_SHIFT > 7) ? 4 : 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vea_pkg::lane_ctrl_t       ctrl,
	input  logic [ADC_BITS-1:0]       raw,
	input  logic [ADC_BITS-1:0]       zero,
	input  logic [SH_W-1:0]           shift,
	output logic [AVG_W-1:0]          avg,
	output logic [DEV_W-1:0]          dev,
	output logic [SQ_W-1:0]           sq
);

	logic [AVG_W-1:0]        over_acc_q;
	logic [AVG_W-1:0]        acc_new;
	logic [AVG_W-1:0]        sum_s1;
	logic [AVG_W-1:0]        avg_c;
	logic [DEV_W-1:0]        dev_c;
	logic [AVG_W-1:0]        avg_s2;
	logic signed [DEV_W-1:0] dev_s2;
	logic signed [SQ_W-1:0]  sq_c;
	logic [AVG_W-1:0]        avg_s3;
	logic [DEV_W-1:0]        dev_s3;
	logic [SQ_W-1:0]         sq_s3;

	assign acc_new = (ctrl.wake ? '0 : over_acc_q) + AVG_W'(raw);
	assign avg_c   = sum_s1 >> shift;
	assign dev_c   = DEV_W'(avg_c) - DEV_W'(zero);
	assign sq_c    = dev_s2 * dev_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_acc_q <= '0;
		end else if (ctrl.take) begin
			over_acc_q <= ctrl.done ? '0 : acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			sum_s1 <= acc_new;
		end
		if (ctrl.en_s2) begin
			avg_s2 <= avg_c;
			dev_s2 <= dev_c;
		end
		if (ctrl.en_s3) begin
			avg_s3 <= avg_s2;
			dev_s3 <= dev_s2;
			sq_s3  <= sq_c;
		end
	end

	assign avg = avg_s3;
	assign dev = dev_s3;
	assign sq  = sq_s3;

endmodule

FILE: sv/vea_merge.sv
// Merge stage: window sums, counters and the output register.
module vea_merge #(
	parameter int ADC_BITS  = 12,
	parameter int MAX_SHIFT = 6,
	localparam int AVG_W = ADC_BITS + MAX_SHIFT,
	localparam int DEV_W = AVG_W + 1,
	localparam int SQ_W  = 2 * DEV_W,
	localparam int OUT_W = vea_pkg::NUM_OUT * vea_pkg::SUM_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  vea_pkg::item_ctrl_t   ctrl,
	input  logic                  calib_mode,
	input  logic [ADC_BITS-1:0]   ntc_one,
	input  logic [ADC_BITS-1:0]   ntc_two,
	input  logic [AVG_W-1:0]      avg [vea_pkg::NUM_AXES],
	input  logic [DEV_W-1:0]      dev [vea_pkg::NUM_AXES],
	input  logic [SQ_W-1:0]       sq  [vea_pkg::NUM_AXES],
	output logic                  move,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_W-1:0]      out_data
);

	localparam int W = vea_pkg::SUM_W;
	localparam int N = vea_pkg::NUM_AXES;

	logic [W-1:0] sq_sum_q  [N];
	logic [W-1:0] dev_sum_q [N];
	logic [W-1:0] raw_sum_q [N];
	logic [W-1:0] ntc_one_q;
	logic [W-1:0] ntc_two_q;
	logic [W-1:0] ntc_cnt_q;
	logic [W-1:0] win_cnt_q;
	logic [W-1:0] tot_cnt_q;
	logic         out_valid_q;

	assign move = item_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int a = 0; a < N; a++) begin
				sq_sum_q[a]  <= '0;
				dev_sum_q[a] <= '0;
				raw_sum_q[a] <= '0;
			end
			ntc_one_q <= '0;
			ntc_two_q <= '0;
			ntc_cnt_q <= '0;
			win_cnt_q <= '0;
			tot_cnt_q <= '0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (move) begin
				if (ctrl.clear) begin
					for (int a = 0; a < N; a++) begin
						sq_sum_q[a]  <= '0;
						dev_sum_q[a] <= '0;
						raw_sum_q[a] <= '0;
					end
					ntc_one_q <= '0;
					ntc_two_q <= '0;
					ntc_cnt_q <= '0;
					win_cnt_q <= '0;
				end else begin
					if (ctrl.wake) begin
						ntc_one_q <= ntc_one_q + W'(ntc_one);
						ntc_two_q <= ntc_two_q + W'(ntc_two);
						ntc_cnt_q <= ntc_cnt_q + W'(1);
					end
					if (ctrl.done) begin
						win_cnt_q <= win_cnt_q + W'(1);
						tot_cnt_q <= tot_cnt_q + W'(1);
						for (int a = 0; a < N; a++) begin
							if (calib_mode) begin
								raw_sum_q[a] <= raw_sum_q[a] + W'(avg[a]);
							end else begin
								sq_sum_q[a]  <= sq_sum_q[a] + W'(sq[a]);
								dev_sum_q[a] <= dev_sum_q[a] + W'(signed'(dev[a]));
							end
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < N; a++) begin
			out_data[a*W +: W]     = sq_sum_q[a];
			out_data[(N+a)*W +: W] = calib_mode ? raw_sum_q[a] : dev_sum_q[a];
		end
		out_data[(2*N)*W +: W]   = ntc_one_q;
		out_data[(2*N+1)*W +: W] = ntc_two_q;
		out_data[(2*N+2)*W +: W] = ntc_cnt_q;
		out_data[(2*N+3)*W +: W] = win_cnt_q;
		out_data[(2*N+4)*W +: W] = tot_cnt_q;
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/vea_checker.sv
// Port-level checker for the vibration energy accumulator and its bind.
`include "assert_macros.svh"

module vea_checker (
	input logic                                            clk,
	input logic                                            arst_n,
	input logic                                            s_axis_tready,
	input logic                                            m_axis_tvalid,
	input logic                                            m_axis_tready,
	input logic [vea_pkg::NUM_OUT*vea_pkg::SUM_W-1:0]      m_axis_tdata
);

	// A result beat that is not taken stays on the bus unchanged.
	`VEA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// With the output register free or draining, the lanes can always take a beat.
	`VEA_ASSERT_IMPL(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)

	// No result is shown while reset is held.
	`VEA_ASSERT_ALWAYS(a_reset_empty, arst_n || !m_axis_tvalid)

endmodule

bind vibration_energy_accumulator vea_checker u_vea_checker (.*);

FILE: tb/sv/tb_vibration_energy_accumulator.sv
// Self-checking testbench for the vibration energy accumulator: stream stimulus, predictor and scoreboard.
`timescale 1ns / 100ps

module tb_vibration_energy_accumulator;

	localparam int ADC_W     = 12;
	localparam int MAX_SHIFT = 6;
	localparam int IN_W      = 64;
	localparam int OUT_W     = vea_pkg::NUM_OUT * vea_pkg::SUM_W;

	class energy_scoreboard;
		logic             calib_mode;
		logic [11:0]      zero_lvl [3];
		logic [2:0]       shift_cfg;
		logic [31:0]      group_acc [3];
		int unsigned      group_count;
		logic [31:0]      square_sum [3];
		logic [31:0]      dev_sum [3];
		logic [31:0]      raw_sum [3];
		logic [31:0]      ntc_sum [2];
		logic [31:0]      ntc_readings;
		logic [31:0]      window_count;
		logic [31:0]      total_count;
		logic [OUT_W-1:0] expected_sums [$];
		int               mismatches;
		string            field_names [11];

		function new();
			calib_mode  = 1'b1;
			shift_cfg   = 3'd2;
			group_count = 0;
			total_count = '0;
			mismatches  = 0;
			for (int a = 0; a < 3; a++) begin
				zero_lvl[a]  = 12'd2048;
				group_acc[a] = '0;
			end
			clear_window();
			field_names = '{"square_sum_x", "square_sum_y", "square_sum_z",
				"linear_sum_x", "linear_sum_y", "linear_sum_z", "ntc_sum_one",
				"ntc_sum_two", "ntc_samples", "window_samples", "all_samples"};
		endfunction

		function void clear_window();
			for (int a = 0; a < 3; a++) begin
				square_sum[a] = '0;
				dev_sum[a]    = '0;
				raw_sum[a]    = '0;
			end
			ntc_sum[0]   = '0;
			ntc_sum[1]   = '0;
			ntc_readings = '0;
			window_count = '0;
		endfunction

		function void set_reg(logic [vea_pkg::CFG_IDX_W-1:0] idx, logic [11:0] value);
			case (idx)
				vea_pkg::REG_CALIB_MODE:       calib_mode  = value[0];
				vea_pkg::REG_ZERO_X:           zero_lvl[0] = value;
				vea_pkg::REG_ZERO_Y:           zero_lvl[1] = value;
				vea_pkg::REG_ZERO_Z:           zero_lvl[2] = value;
				vea_pkg::REG_OVERSAMPLE_SHIFT: shift_cfg   = value[vea_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_beat(logic op, logic wake, logic [11:0] rx, logic [11:0] ry,
			logic [11:0] rz, logic [11:0] n1, logic [11:0] n2);
			logic [11:0] raw [3];
			int          sh;
			logic [31:0] avg;
			longint      dev;
			longint      sq;
			logic [31:0] linear [3];
			raw[0] = rx;
			raw[1] = ry;
			raw[2] = rz;
			if (op) begin
				clear_window();
			end else begin
				sh = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : int'(shift_cfg);
				if (wake) begin
					for (int a = 0; a < 3; a++) group_acc[a] = '0;
					group_count = 0;
					ntc_sum[0]   = ntc_sum[0] + n1;
					ntc_sum[1]   = ntc_sum[1] + n2;
					ntc_readings = ntc_readings + 1;
				end
				for (int a = 0; a < 3; a++) group_acc[a] = group_acc[a] + raw[a];
				group_count++;
				if (group_count >= (1 << sh)) begin
					for (int a = 0; a < 3; a++) begin
						avg = group_acc[a] >> sh;
						if (calib_mode) begin
							raw_sum[a] = raw_sum[a] + avg;
						end else begin
							dev = longint'(avg) - longint'(zero_lvl[a]);
							sq  = dev * dev;
							square_sum[a] = square_sum[a] + sq[31:0];
							dev_sum[a]    = dev_sum[a] + dev[31:0];
						end
						group_acc[a] = '0;
					end
					group_count  = 0;
					window_count = window_count + 1;
					total_count  = total_count + 1;
				end
			end
			for (int a = 0; a < 3; a++) linear[a] = calib_mode ? raw_sum[a] : dev_sum[a];
			expected_sums.push_back({total_count, window_count, ntc_readings, ntc_sum[1],
				ntc_sum[0], linear[2], linear[1], linear[0], square_sum[2], square_sum[1],
				square_sum[0]});
		endfunction

		function void check_sums(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Result beat arrived with no expectation waiting.");
				return;
			end
			want = expected_sums.pop_front();
			for (int f = 0; f < vea_pkg::NUM_OUT; f++) begin
				if (got[f*vea_pkg::SUM_W +: vea_pkg::SUM_W] !==
					want[f*vea_pkg::SUM_W +: vea_pkg::SUM_W]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch in %s: expected %0d, got %0d", field_names[f],
							want[f*vea_pkg::SUM_W +: vea_pkg::SUM_W],
							got[f*vea_pkg::SUM_W +: vea_pkg::SUM_W]);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [vea_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ADC_W-1:0]              cfg_data;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [IN_W-1:0]               s_axis_tdata;
	logic [1:0]                    s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [OUT_W-1:0]              m_axis_tdata;

	energy_scoreboard sums_board;
	int               send_idle_pct;
	int               recv_stall_pct;

	vibration_energy_accumulator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) sums_board.check_sums(m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [11:0] rand_adc(bit hot);
		int r;
		r = $urandom_range(0, 99);
		if (hot && r < 80) return 12'd4095;
		if (r < 8) return 12'd0;
		if (r < 16) return 12'd4095;
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic send_beat(input logic op, input logic wake, input logic [11:0] rx,
		input logic [11:0] ry, input logic [11:0] rz, input logic [11:0] n1,
		input logic [11:0] n2);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {wake, op};
		s_axis_tdata  <= {4'd0, n2, n1, rz, ry, rx};
		do @(posedge clk); while (!s_axis_tready);
		sums_board.note_beat(op, wake, rx, ry, rz, n1, n2);
	endtask

	task automatic pause_sender(input int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		while (sums_board.expected_sums.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [vea_pkg::CFG_IDX_W-1:0] idx,
		input logic [11:0] value);
		sums_board.set_reg(idx, value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input logic cal, input logic [11:0] zx, input logic [11:0] zy,
		input logic [11:0] zz, input logic [2:0] sh, input int items, input int mode,
		input int clear_pct, input bit hot);
		int   eff;
		logic op;
		logic wake;
		write_reg(vea_pkg::REG_CALIB_MODE, {11'd0, cal});
		write_reg(vea_pkg::REG_ZERO_X, zx);
		write_reg(vea_pkg::REG_ZERO_Y, zy);
		write_reg(vea_pkg::REG_ZERO_Z, zz);
		write_reg(vea_pkg::REG_OVERSAMPLE_SHIFT, {9'd0, sh});
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
		eff = (sh > MAX_SHIFT) ? MAX_SHIFT : int'(sh);
		for (int i = 0; i < items; i++) begin
			op   = ($urandom_range(0, 99) < clear_pct);
			wake = ($urandom_range(0, 4 << eff) == 0);
			send_beat(op, wake, rand_adc(hot), rand_adc(hot), rand_adc(hot),
				rand_adc(1'b0), rand_adc(1'b0));
			if (i == items - 1 || (mode == 1 && i == items / 2)) begin
				pause_sender(1);
				drain();
			end else begin
				while ($urandom_range(0, 99) < send_idle_pct) pause_sender(1);
			end
		end
	endtask

	initial begin
		sums_board     = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: calibration mode, groups of four conversions.
		send_beat(1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_beat(1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0);
		send_beat(1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_beat(1'b0, 1'b0, 12'd1, 12'd2, 12'd3, 12'd0, 12'd0);
		send_beat(1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_beat(1'b0, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_beat(1'b0, 1'b0, 12'd100, 12'd200, 12'd300, 12'd0, 12'd0);
		send_beat(1'b0, 1'b1, 12'd5, 12'd6, 12'd7, 12'd1, 12'd2);
		pause_sender(1);
		drain();

		// The group above is still open when the shift drops to zero.
		write_reg(vea_pkg::REG_CALIB_MODE, 12'd0);
		write_reg(vea_pkg::REG_ZERO_X, 12'd0);
		write_reg(vea_pkg::REG_ZERO_Y, 12'd4095);
		write_reg(vea_pkg::REG_ZERO_Z, 12'd2048);
		write_reg(vea_pkg::REG_OVERSAMPLE_SHIFT, 12'd0);
		send_beat(1'b0, 1'b0, 12'd4095, 12'd0, 12'd2048, 12'd0, 12'd0);
		send_beat(1'b0, 1'b0, 12'd0, 12'd4095, 12'd2048, 12'd0, 12'd0);
		send_beat(1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0);
		send_beat(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_beat(1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0);
		pause_sender(1);
		drain();
		write_reg(vea_pkg::REG_OVERSAMPLE_SHIFT, 12'd1);
		send_beat(1'b0, 1'b1, 12'd4095, 12'd1, 12'd2048, 12'd0, 12'd4095);
		send_beat(1'b0, 1'b0, 12'd4094, 12'd0, 12'd2047, 12'd0, 12'd0);
		send_beat(1'b0, 1'b0, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd0);
		pause_sender(1);
		drain();

		run_phase(1'b1, 12'd2048, 12'd2048, 12'd2048, 3'd2, 160, 0, 2, 1'b0);
		run_phase(1'b0, 12'd2048, 12'd2048, 12'd2048, 3'd2, 160, 1, 2, 1'b0);
		run_phase(1'b0, 12'd0, 12'd4095, 12'd0, 3'd0, 160, 2, 2, 1'b0);
		run_phase(1'b0, 12'd4095, 12'd4095, 12'd4095, 3'd7, 160, 3, 1, 1'b0);
		run_phase(1'b1, 12'd1000, 12'd3000, 12'd17, 3'd6, 160, 0, 1, 1'b0);
		run_phase(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 3'd1, 160, 1, 2, 1'b0);
		// Large deviations with no clears so the square sums wrap.
		run_phase(1'b0, 12'd0, 12'd0, 12'd0, 3'd0, 300, 3, 0, 1'b1);
		run_phase(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 3'd3, 160, 2, 2, 1'b0);
		run_phase(1'b1, 12'd4095, 12'd0, 12'd2048, 3'd5, 160, 3, 1, 1'b0);
		run_phase(1'b0, 12'd2048, 12'd1, 12'd4094, 3'd4, 160, 0, 2, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (sums_board.mismatches == 0 && sums_board.expected_sums.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
